// File: design/cirq_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cirq_pkg
// Types and constants shared by the cartridge timer and register block.
// ----------------------------------------------------------------------------
package cirq_pkg;

   localparam int unsigned AddrWidth  = 12;
   localparam int unsigned DataWidth  = 8;
   localparam int unsigned FontWidth  = 18;
   localparam int unsigned CountWidth = 16;
   localparam int unsigned FcntWidth  = 5;

   typedef enum logic [1:0] {
      FUNC_READ  = 2'd0,
      FUNC_WRITE = 2'd1,
      FUNC_TICK  = 2'd2,
      FUNC_FONT  = 2'd3
   } func_type;

   localparam logic [AddrWidth-1:0] ADDR_APU_LIMIT  = 12'h020;
   localparam logic [AddrWidth-1:0] ADDR_IRQ_ACK    = 12'h0A2;
   localparam logic [AddrWidth-1:0] ADDR_RELOAD_LO  = 12'h0A6;
   localparam logic [AddrWidth-1:0] ADDR_RELOAD_HI  = 12'h0A7;
   localparam logic [AddrWidth-1:0] ADDR_TIMER_CTRL = 12'h0A8;
   localparam logic [AddrWidth-1:0] ADDR_MIRROR     = 12'h0AD;
   localparam logic [AddrWidth-1:0] ADDR_RAM_CTRL_B = 12'h0AE;
   localparam logic [AddrWidth-1:0] ADDR_FONT       = 12'h0B0;
   localparam logic [AddrWidth-1:0] ADDR_RAM_CTRL_A = 12'h0C0;
   localparam logic [AddrWidth-1:0] ADDR_SCRATCH_LO = 12'h0D0;
   localparam logic [AddrWidth-1:0] ADDR_SCRATCH_HI = 12'h0D3;

   localparam logic [DataWidth-1:0] RAM_CTRL_FORCE = 8'h87;
   localparam logic [DataWidth-1:0] OPEN_BUS       = 8'hFF;

   // Packed so that read_data sits in the lowest bits.
   typedef struct packed {
      logic                 wram_override;
      logic                 chr_ram_page;
      logic                 mirror_horizontal;
      logic                 irq_n;
      logic [FontWidth-1:0] font_rom_address;
      logic                 apu_passthrough;
      logic [DataWidth-1:0] read_data;
   } result_type;

endpackage
`default_nettype wire

// File: design/cirq_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cirq_regs
// Register file, interval timer and font counter; forms one result per word.
// ----------------------------------------------------------------------------
module cirq_regs
   import cirq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 step_valid,
   input  wire func_type             func,
   input  wire logic [AddrWidth-1:0] addr,
   input  wire logic [DataWidth-1:0] write_data,
   output result_type                result
);

   logic [CountWidth-1:0] reload_latch_ff, reload_latch_in;
   logic [CountWidth-1:0] down_counter_ff, down_counter_in;
   logic                  timer_enabled_ff, timer_enabled_in;
   logic                  timer_repeat_ff, timer_repeat_in;
   logic                  irq_pending_ff, irq_pending_in;
   logic [DataWidth-1:0]  mirroring_ff, mirroring_in;
   logic [DataWidth-1:0]  ram_ctrl_a_ff, ram_ctrl_a_in;
   logic [DataWidth-1:0]  ram_ctrl_b_ff, ram_ctrl_b_in;
   logic                  font_bank_ff, font_bank_in;
   logic [FcntWidth-1:0]  font_count_ff, font_count_in;
   logic [DataWidth-1:0]  scratch_ff [4];
   logic [DataWidth-1:0]  scratch_in [4];

   logic                  is_scratch;
   logic                  is_apu;
   logic [DataWidth-1:0]  rd;
   logic                  apu;
   logic [FontWidth-1:0]  fa;

   assign is_scratch = (addr >= ADDR_SCRATCH_LO) && (addr <= ADDR_SCRATCH_HI);
   assign is_apu     = addr < ADDR_APU_LIMIT;

   always_comb begin
      reload_latch_in  = reload_latch_ff;
      down_counter_in  = down_counter_ff;
      timer_enabled_in = timer_enabled_ff;
      timer_repeat_in  = timer_repeat_ff;
      irq_pending_in   = irq_pending_ff;
      mirroring_in     = mirroring_ff;
      ram_ctrl_a_in    = ram_ctrl_a_ff;
      ram_ctrl_b_in    = ram_ctrl_b_ff;
      font_bank_in     = font_bank_ff;
      font_count_in    = font_count_ff;
      scratch_in       = scratch_ff;
      rd               = '0;
      apu              = 1'b0;
      fa               = '0;

      unique case (func)
         FUNC_READ: begin
            rd = OPEN_BUS;
            if (is_apu) begin
               apu = 1'b1;
            end else begin
               priority if (addr == ADDR_IRQ_ACK) begin
                  rd             = {{(DataWidth-1){1'b0}}, irq_pending_ff};
                  irq_pending_in = 1'b0;
               end else if (addr == ADDR_MIRROR) begin
                  rd = mirroring_ff;
               end else if (addr == ADDR_FONT) begin
                  font_count_in = '0;
               end else if (addr == ADDR_RAM_CTRL_A) begin
                  rd = ram_ctrl_a_ff | RAM_CTRL_FORCE;
               end else if (is_scratch) begin
                  rd = scratch_ff[addr[1:0]];
               end else begin
                  rd = OPEN_BUS;
               end
            end
         end
         FUNC_WRITE: begin
            if (is_apu) begin
               apu = 1'b1;
            end else begin
               priority if (addr == ADDR_RELOAD_LO) begin
                  reload_latch_in = {reload_latch_ff[CountWidth-1:DataWidth], write_data};
               end else if (addr == ADDR_RELOAD_HI) begin
                  reload_latch_in = {write_data, reload_latch_ff[DataWidth-1:0]};
               end else if (addr == ADDR_TIMER_CTRL) begin
                  timer_repeat_in  = write_data[0];
                  timer_enabled_in = write_data[1];
                  // Enabling reloads the counter; disabling drops any pending interrupt.
                  if (write_data[1]) begin
                     down_counter_in = reload_latch_ff;
                  end else begin
                     irq_pending_in = 1'b0;
                  end
               end else if (addr == ADDR_MIRROR) begin
                  mirroring_in = write_data;
               end else if (addr == ADDR_RAM_CTRL_B) begin
                  ram_ctrl_b_in = write_data;
               end else if (addr == ADDR_FONT) begin
                  font_bank_in = write_data[0];
               end else if (addr == ADDR_RAM_CTRL_A) begin
                  ram_ctrl_a_in = write_data;
               end else if (is_scratch) begin
                  scratch_in[addr[1:0]] = write_data;
               end else begin
                  apu = 1'b0;
               end
            end
         end
         FUNC_TICK: begin
            if (timer_enabled_ff) begin
               if (down_counter_ff == '0) begin
                  irq_pending_in = 1'b1;
                  if (timer_repeat_ff) begin
                     down_counter_in = reload_latch_ff;
                  end else begin
                     timer_enabled_in = 1'b0;
                  end
               end else begin
                  down_counter_in = down_counter_ff - 1'b1;
               end
            end
         end
         FUNC_FONT: begin
            fa            = {font_bank_ff, addr, font_count_ff};
            font_count_in = font_count_ff + 1'b1;
         end
         default: begin
            rd = '0;
         end
      endcase
   end

   always_comb begin
      result.read_data         = rd;
      result.apu_passthrough   = apu;
      result.font_rom_address  = fa;
      result.irq_n             = ~irq_pending_ff;
      result.mirror_horizontal = mirroring_in[7];
      result.chr_ram_page      = ram_ctrl_a_in[3];
      result.wram_override     = ram_ctrl_a_in[0] & ram_ctrl_b_in[0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_latch_ff  <= '0;
         down_counter_ff  <= '0;
         timer_enabled_ff <= 1'b0;
         timer_repeat_ff  <= 1'b0;
         irq_pending_ff   <= 1'b0;
         mirroring_ff     <= '0;
         ram_ctrl_a_ff    <= '0;
         ram_ctrl_b_ff    <= '0;
         font_bank_ff     <= 1'b0;
         font_count_ff    <= '0;
         scratch_ff       <= '{default: '0};
      end else if (step_valid) begin
         reload_latch_ff  <= reload_latch_in;
         down_counter_ff  <= down_counter_in;
         timer_enabled_ff <= timer_enabled_in;
         timer_repeat_ff  <= timer_repeat_in;
         irq_pending_ff   <= irq_pending_in;
         mirroring_ff     <= mirroring_in;
         ram_ctrl_a_ff    <= ram_ctrl_a_in;
         ram_ctrl_b_ff    <= ram_ctrl_b_in;
         font_bank_ff     <= font_bank_in;
         font_count_ff    <= font_count_in;
         scratch_ff       <= scratch_in;
      end
   end

`ifndef SYNTHESIS
   a_irq_ack_clears: assert property (@(posedge clock) disable iff (reset)
      step_valid && func == FUNC_READ && addr == ADDR_IRQ_ACK |=> !irq_pending_ff)
      else $error("interrupt still pending after acknowledge read");

   a_timer_stop_cause: assert property (@(posedge clock) disable iff (reset)
      $fell(timer_enabled_ff) && $past(!reset) |->
         $past(step_valid) && ($past(func) == FUNC_TICK ||
         ($past(func) == FUNC_WRITE && $past(addr) == ADDR_TIMER_CTRL)))
      else $error("timer stopped without a tick or a control write");

   a_apu_no_state: assert property (@(posedge clock) disable iff (reset)
      step_valid && is_apu && (func == FUNC_READ || func == FUNC_WRITE) |=>
         $stable(reload_latch_ff) && $stable(irq_pending_ff) &&
         $stable(mirroring_ff) && $stable(font_count_ff) && $stable(ram_ctrl_a_ff))
      else $error("sound passthrough access changed local state");

   a_font_count_step: assert property (@(posedge clock) disable iff (reset)
      step_valid && func == FUNC_FONT |=>
         font_count_ff == FcntWidth'($past(font_count_ff) + 1'b1))
      else $error("font counter did not advance on a font read");
`endif

endmodule
`default_nettype wire

// File: design/cartridge_irq_timer_registers.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cartridge_irq_timer_registers
// Cartridge register block with interval timer, mirroring, RAM control,
// scratch bytes and font ROM address generation.
// ----------------------------------------------------------------------------
// Usage:
//   The req_ channel carries one word per bus access or CPU cycle: tuser holds
//   the kind (register read, register write, cycle tick, font read) and tdata
//   holds the offset and the write byte. Every word, ticks included, yields
//   exactly one word on the rsp_ channel with the read byte, the sound
//   passthrough flag, the font ROM address, the interrupt line and the
//   mirroring and RAM control outputs.
//   A word is held in the input register, is evaluated against the register
//   state and lands in the output register, which presents the result on
//   rsp_. One word is taken every cycle while rsp_tready stays high; there is
//   only the single evaluation stage between the two registers.
//   When rsp_tready is low the output register holds its word, the input
//   register fills, and req_tready drops until the output drains.
//   Reset clears every register, the timer and the interrupt, and empties
//   both pipeline registers.
// ----------------------------------------------------------------------------
module cartridge_irq_timer_registers
   import cirq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [23:0] req_tdata,   // addr[11:0], write_data[19:12], zero[23:20]
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [31:0]      rsp_tdata    // read_data[7:0], apu_passthrough[8],
                                         // font_rom_address[26:9], irq_n[27],
                                         // mirror_horizontal[28], chr_ram_page[29],
                                         // wram_override[30], zero[31]
);

   logic                 in_valid_ff, in_valid_in;
   func_type             in_func_ff;
   logic [AddrWidth-1:0] in_addr_ff;
   logic [DataWidth-1:0] in_data_ff;
   logic                 out_valid_ff, out_valid_in;
   result_type           out_word_ff;
   result_type           result;
   logic                 out_free;
   logic                 step;
   logic                 req_take;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (step) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (step) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_func_ff <= func_type'(req_tuser);
         in_addr_ff <= req_tdata[AddrWidth-1:0];
         in_data_ff <= req_tdata[AddrWidth+DataWidth-1:AddrWidth];
      end
      if (step) begin
         out_word_ff <= result;
      end
   end

   cirq_regs u_regs (
      .clock      (clock),
      .reset      (reset),
      .step_valid (step),
      .func       (in_func_ff),
      .addr       (in_addr_ff),
      .write_data (in_data_ff),
      .result     (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_word_ff};

endmodule
`default_nettype wire

// File: sim/cartridge_irq_timer_registers_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_irq_timer_registers_checker
// Watches both streams of the cartridge register block. Each accepted request
// word updates a private copy of the timer and register state, which yields
// the expected response word. Responses are compared field by field, in order.
// ----------------------------------------------------------------------------
module cartridge_irq_timer_registers_checker
   import cirq_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [23:0] req_tdata,   // addr[11:0], write_data[19:12], zero[23:20]
   input  wire logic [1:0]  req_tuser,   // func[1:0]
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [31:0] rsp_tdata,   // read_data[7:0], apu_passthrough[8],
                                         // font_rom_address[26:9], irq_n[27],
                                         // mirror_horizontal[28], chr_ram_page[29],
                                         // wram_override[30], zero[31]
   output int               fail_count,
   output int               pending_count
);

   logic [15:0]          reload_value;
   logic [15:0]          count_value;
   logic                 timer_on;
   logic                 timer_rearm;
   logic                 irq_flag;
   logic [7:0]           mirror_q;
   logic [7:0]           ram_a_q;
   logic [7:0]           ram_b_q;
   logic                 font_bank_q;
   logic [FcntWidth-1:0] font_index;
   logic [7:0]           scratch_q [4];

   result_type expected_words [$];

   // Applies one request word to the shadow state and returns the response.
   task automatic apply_word(input func_type f, input logic [11:0] a,
                             input logic [7:0] d, output result_type r);
      r = '0;
      r.irq_n = !irq_flag;
      case (f)
         FUNC_READ: begin
            r.read_data = OPEN_BUS;
            if (a < ADDR_APU_LIMIT) begin
               r.apu_passthrough = 1'b1;
            end else if (a == ADDR_IRQ_ACK) begin
               r.read_data = {7'd0, irq_flag};
               irq_flag = 1'b0;
            end else if (a == ADDR_MIRROR) begin
               r.read_data = mirror_q;
            end else if (a == ADDR_FONT) begin
               font_index = '0;
            end else if (a == ADDR_RAM_CTRL_A) begin
               r.read_data = ram_a_q | RAM_CTRL_FORCE;
            end else if (a >= ADDR_SCRATCH_LO && a <= ADDR_SCRATCH_HI) begin
               r.read_data = scratch_q[a[1:0]];
            end
         end
         FUNC_WRITE: begin
            if (a < ADDR_APU_LIMIT) begin
               r.apu_passthrough = 1'b1;
            end else if (a == ADDR_RELOAD_LO) begin
               reload_value[7:0] = d;
            end else if (a == ADDR_RELOAD_HI) begin
               reload_value[15:8] = d;
            end else if (a == ADDR_TIMER_CTRL) begin
               timer_rearm = d[0];
               timer_on    = d[1];
               // Enabling restarts the count; disabling drops any pending interrupt.
               if (d[1]) count_value = reload_value;
               else irq_flag = 1'b0;
            end else if (a == ADDR_MIRROR) begin
               mirror_q = d;
            end else if (a == ADDR_RAM_CTRL_B) begin
               ram_b_q = d;
            end else if (a == ADDR_FONT) begin
               font_bank_q = d[0];
            end else if (a == ADDR_RAM_CTRL_A) begin
               ram_a_q = d;
            end else if (a >= ADDR_SCRATCH_LO && a <= ADDR_SCRATCH_HI) begin
               scratch_q[a[1:0]] = d;
            end
         end
         FUNC_TICK: begin
            if (timer_on) begin
               if (count_value == 16'd0) begin
                  irq_flag = 1'b1;
                  if (timer_rearm) count_value = reload_value;
                  else timer_on = 1'b0;
               end else begin
                  count_value = count_value - 16'd1;
               end
            end
         end
         default: begin
            r.font_rom_address = {font_bank_q, a, font_index};
            font_index = font_index + 1'b1;
         end
      endcase
      r.mirror_horizontal = mirror_q[7];
      r.chr_ram_page      = ram_a_q[3];
      r.wram_override     = ram_a_q[0] & ram_b_q[0];
   endtask

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      result_type got;
      if (reset) begin
         reload_value = '0;
         count_value  = '0;
         timer_on     = 1'b0;
         timer_rearm  = 1'b0;
         irq_flag     = 1'b0;
         mirror_q     = '0;
         ram_a_q      = '0;
         ram_b_q      = '0;
         font_bank_q  = 1'b0;
         font_index   = '0;
         for (int i = 0; i < 4; i++) scratch_q[i] = '0;
         expected_words.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            apply_word(func_type'(req_tuser), req_tdata[11:0], req_tdata[19:12], want);
            expected_words.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = result_type'(rsp_tdata[30:0]);
            if (expected_words.size() == 0) begin
               $error("response word %h arrived with nothing expected", rsp_tdata);
               fail_count++;
            end else begin
               want = expected_words.pop_front();
               check_field("read_data", want.read_data, got.read_data);
               check_field("apu_passthrough", want.apu_passthrough, got.apu_passthrough);
               check_field("font_rom_address", want.font_rom_address,
                           got.font_rom_address);
               check_field("irq_n", want.irq_n, got.irq_n);
               check_field("mirror_horizontal", want.mirror_horizontal,
                           got.mirror_horizontal);
               check_field("chr_ram_page", want.chr_ram_page, got.chr_ram_page);
               check_field("wram_override", want.wram_override, got.wram_override);
            end
         end
      end
      pending_count <= expected_words.size();
   end

endmodule

// File: sim/cartridge_irq_timer_registers_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cartridge_irq_timer_registers_tb
// Drives register accesses, timer ticks and font reads into the cartridge
// register block in bursts, with a stalling response side, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module cartridge_irq_timer_registers_tb;
   import cirq_pkg::*;

   localparam int ItemTarget  = 700;
   localparam int HoldCycles  = 300;
   localparam int IdleLimit   = 2000;

   typedef enum int {RX_STREAM, RX_RANDOM, RX_PERIODIC} rx_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [23:0] req_tdata  = '0;
   logic [1:0]  req_tuser  = '0;
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [31:0] rsp_tdata;

   int fail_count;
   int pending_count;
   int burst_left    = 0;
   int items_sent    = 0;
   int hold_requests = 0;
   int holds_served  = 0;
   int idle_cycles   = 0;

   always #4 clock = ~clock;

   cartridge_irq_timer_registers dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   cartridge_irq_timer_registers_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   // Offers one word, opening a new burst after a random gap when needed.
   task automatic send_word(input func_type f, input logic [11:0] a,
                            input logic [7:0] d);
      int gap_cycles;
      if (burst_left == 0) begin
         gap_cycles = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         repeat (gap_cycles) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 120)
                                                  : $urandom_range(1, 16);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {4'd0, d, a};
      req_tuser  <= f;
      do @(posedge clock); while (!req_tready);
      burst_left--;
      items_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      burst_left = 0;
   endtask

   function automatic logic [11:0] random_register();
      case ($urandom_range(0, 10))
         0:       return ADDR_IRQ_ACK;
         1:       return ADDR_RELOAD_LO;
         2:       return ADDR_RELOAD_HI;
         3:       return ADDR_TIMER_CTRL;
         4:       return ADDR_MIRROR;
         5:       return ADDR_RAM_CTRL_B;
         6:       return ADDR_FONT;
         7:       return ADDR_RAM_CTRL_A;
         default: return ADDR_SCRATCH_LO + 12'($urandom_range(0, 3));
      endcase
   endfunction

   function automatic logic [11:0] random_offset();
      case ($urandom_range(0, 3))
         0:       return 12'($urandom);
         1:       return 12'($urandom_range(0, 255));
         2:       return 12'($urandom_range(0, 31));
         default: return random_register();
      endcase
   endfunction

   // Response side: changing stall patterns, plus long hold-offs on request.
   initial begin
      rx_mode_type rx_mode;
      int          mode_left;
      int          phase;
      rx_mode   = RX_STREAM;
      mode_left = 0;
      phase     = 0;
      forever begin
         @(negedge clock);
         if (holds_served < hold_requests) begin
            holds_served++;
            rsp_tready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
         end
         if (mode_left == 0) begin
            rx_mode   = rx_mode_type'($urandom_range(0, 2));
            mode_left = $urandom_range(20, 80);
         end
         mode_left--;
         phase++;
         case (rx_mode)
            RX_STREAM:   rsp_tready <= 1'b1;
            RX_RANDOM:   rsp_tready <= 1'($urandom_range(0, 1));
            default:     rsp_tready <= (phase % 5) > 1;
         endcase
      end
   end

   // Ends the run if neither stream moves for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IdleLimit) begin
         $display("cartridge_irq_timer_registers_tb failed");
         $finish;
      end
   end

   initial begin
      int  run_length;
      bit  hold_asked;
      bit  pause_done;
      hold_asked = 1'b0;
      pause_done = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: passthrough edges, register read-back, timer and font paths.
      send_word(FUNC_READ,  12'h000, 8'h00);
      send_word(FUNC_WRITE, 12'h01F, 8'hFF);
      send_word(FUNC_READ,  ADDR_APU_LIMIT, 8'h00);
      send_word(FUNC_READ,  12'hFFF, 8'h00);
      send_word(FUNC_WRITE, ADDR_MIRROR, 8'h80);
      send_word(FUNC_READ,  ADDR_MIRROR, 8'h00);
      send_word(FUNC_WRITE, ADDR_RAM_CTRL_A, 8'hFF);
      send_word(FUNC_WRITE, ADDR_RAM_CTRL_B, 8'h01);
      send_word(FUNC_READ,  ADDR_RAM_CTRL_A, 8'h00);
      send_word(FUNC_WRITE, ADDR_SCRATCH_LO, 8'hA5);
      send_word(FUNC_WRITE, ADDR_SCRATCH_HI, 8'h5A);
      send_word(FUNC_READ,  ADDR_SCRATCH_HI, 8'h00);
      send_word(FUNC_TICK,  12'h000, 8'h00);
      send_word(FUNC_WRITE, ADDR_RELOAD_LO, 8'h02);
      send_word(FUNC_WRITE, ADDR_RELOAD_HI, 8'h00);
      send_word(FUNC_WRITE, ADDR_TIMER_CTRL, 8'h03);
      repeat (4) send_word(FUNC_TICK, 12'h000, 8'h00);
      send_word(FUNC_READ,  ADDR_IRQ_ACK, 8'h00);
      send_word(FUNC_READ,  ADDR_IRQ_ACK, 8'h00);
      send_word(FUNC_WRITE, ADDR_FONT, 8'h01);
      send_word(FUNC_FONT,  12'hFFF, 8'h00);
      send_word(FUNC_FONT,  12'h000, 8'h00);
      send_word(FUNC_READ,  ADDR_FONT, 8'h00);
      send_word(FUNC_FONT,  12'h555, 8'h00);

      while (items_sent < ItemTarget) begin
         if (!hold_asked && items_sent >= 250) begin
            hold_asked = 1'b1;
            hold_requests++;
         end
         if ((!pause_done && items_sent >= 450) || $urandom_range(0, 29) == 0) begin
            pause_done = 1'b1;
            drain_results();
         end
         case ($urandom_range(0, 3))
            0: begin
               // Program the timer, then run it with an occasional acknowledge.
               send_word(FUNC_WRITE, ADDR_RELOAD_LO,
                         ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                     : 8'($urandom_range(0, 12)));
               send_word(FUNC_WRITE, ADDR_RELOAD_HI,
                         ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00);
               send_word(FUNC_WRITE, ADDR_TIMER_CTRL,
                         8'($urandom) | (($urandom_range(0, 3) != 0) ? 8'h02 : 8'h00));
               run_length = $urandom_range(3, 40);
               repeat (run_length) begin
                  if ($urandom_range(0, 5) == 0) send_word(FUNC_READ, ADDR_IRQ_ACK, 8'($urandom));
                  else send_word(FUNC_TICK, 12'($urandom), 8'($urandom));
               end
            end
            1: begin
               // Register write followed by a read of some mapped register.
               run_length = $urandom_range(1, 6);
               repeat (run_length) begin
                  send_word(FUNC_WRITE, random_register(), 8'($urandom));
                  send_word(FUNC_READ, random_register(), 8'($urandom));
               end
            end
            2: begin
               // Font reads; long runs carry the auto-increment past its wrap.
               send_word(FUNC_WRITE, ADDR_FONT, 8'($urandom));
               run_length = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 40)
                                                        : $urandom_range(1, 10);
               repeat (run_length) begin
                  if ($urandom_range(0, 15) == 0) send_word(FUNC_READ, ADDR_FONT, 8'($urandom));
                  else send_word(FUNC_FONT, 12'($urandom), 8'($urandom));
               end
            end
            default: begin
               run_length = $urandom_range(1, 8);
               repeat (run_length)
                  send_word(func_type'($urandom_range(0, 3)), random_offset(), 8'($urandom));
            end
         endcase
      end

      drain_results();
      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("cartridge_irq_timer_registers_tb passed");
      end else begin
         $display("cartridge_irq_timer_registers_tb failed");
      end
      $finish;
   end

endmodule

// File: cartridge_irq_timer_registers.f
design/cirq_pkg.sv
design/cirq_regs.sv
design/cartridge_irq_timer_registers.sv
sim/cartridge_irq_timer_registers_checker.sv
sim/cartridge_irq_timer_registers_tb.sv
